FILE: hw/rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, constants and square lookups of the Playfair stream encryptor.
// ----------------------------------------------------------------------------
package plf_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [6:0] ascii_type;
   typedef logic [7:0] byte_type;
   typedef logic [2:0] coord_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } pos_type;

   typedef struct packed {
      letter_type first;
      letter_type second;
   } digraph_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;

   localparam byte_type BYTE_UPPER_A = 8'd65;
   localparam byte_type BYTE_UPPER_Z = 8'd90;
   localparam byte_type BYTE_LOWER_A = 8'd97;
   localparam byte_type BYTE_LOWER_Z = 8'd122;

   localparam ascii_type ASCII_A = 7'd97;
   localparam ascii_type ASCII_J = 7'd106;
   localparam ascii_type ASCII_Z = 7'd122;

   localparam coord_type LAST_COORD = 3'd4;

   localparam ascii_type SQUARE [5][5] = '{
      '{7'd101, 7'd115, 7'd109, 7'd112, 7'd105},
      '{7'd111, 7'd108, 7'd97,  7'd121, 7'd102},
      '{7'd114, 7'd98,  7'd99,  7'd100, 7'd103},
      '{7'd104, 7'd107, 7'd110, 7'd113, 7'd116},
      '{7'd117, 7'd118, 7'd119, 7'd120, 7'd122}
   };

   // position of a letter in the square; j shares the cell of i
   function automatic pos_type pos_of(input letter_type l);
      pos_type p;
      unique case (l)
         5'd0:    p = '{3'd1, 3'd2};
         5'd1:    p = '{3'd2, 3'd1};
         5'd2:    p = '{3'd2, 3'd2};
         5'd3:    p = '{3'd2, 3'd3};
         5'd4:    p = '{3'd0, 3'd0};
         5'd5:    p = '{3'd1, 3'd4};
         5'd6:    p = '{3'd2, 3'd4};
         5'd7:    p = '{3'd3, 3'd0};
         5'd8:    p = '{3'd0, 3'd4};
         5'd9:    p = '{3'd0, 3'd4};
         5'd10:   p = '{3'd3, 3'd1};
         5'd11:   p = '{3'd1, 3'd1};
         5'd12:   p = '{3'd0, 3'd2};
         5'd13:   p = '{3'd3, 3'd2};
         5'd14:   p = '{3'd1, 3'd0};
         5'd15:   p = '{3'd0, 3'd3};
         5'd16:   p = '{3'd3, 3'd3};
         5'd17:   p = '{3'd2, 3'd0};
         5'd18:   p = '{3'd0, 3'd1};
         5'd19:   p = '{3'd3, 3'd4};
         5'd20:   p = '{3'd4, 3'd0};
         5'd21:   p = '{3'd4, 3'd1};
         5'd22:   p = '{3'd4, 3'd2};
         5'd23:   p = '{3'd4, 3'd3};
         5'd24:   p = '{3'd1, 3'd3};
         5'd25:   p = '{3'd4, 3'd4};
         default: p = '{3'd4, 3'd3};
      endcase
      return p;
   endfunction

   function automatic coord_type next_coord(input coord_type c);
      return (c == LAST_COORD) ? 3'd0 : coord_type'(c + 3'd1);
   endfunction

   function automatic ascii_type ascii_at(input pos_type p);
      return SQUARE[p.row][p.col];
   endfunction

endpackage

FILE: hw/rtl/plf_req_if.sv
// ----------------------------------------------------------------------------
// plf_req_if
// Valid/ready channel carrying raw text bytes into the encryptor.
// ----------------------------------------------------------------------------
interface plf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_message;

   modport source (output valid, output char_in, output end_of_message, input ready);
   modport sink (input valid, input char_in, input end_of_message, output ready);
endinterface

FILE: hw/rtl/plf_rsp_if.sv
// ----------------------------------------------------------------------------
// plf_rsp_if
// Valid/ready channel carrying ciphertext letters out of the encryptor.
// ----------------------------------------------------------------------------
interface plf_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] cipher_letter;
   logic       last_of_run;
   logic       message_done;

   modport source (
      output valid, output cipher_letter, output last_of_run, output message_done,
      input ready
   );
   modport sink (
      input valid, input cipher_letter, input last_of_run, input message_done,
      output ready
   );
endinterface

FILE: hw/rtl/plf_digraph_enc.sv
// ----------------------------------------------------------------------------
// plf_digraph_enc
// Encrypts one plaintext digraph with the fixed 5x5 square.
// ----------------------------------------------------------------------------
module plf_digraph_enc (
   input  plf_pkg::digraph_type pair,
   output plf_pkg::ascii_type   cipher_first,
   output plf_pkg::ascii_type   cipher_second
);
   import plf_pkg::*;

   pos_type p;
   pos_type q;
   pos_type x;
   pos_type y;

   assign p = pos_of(pair.first);
   assign q = pos_of(pair.second);

   always_comb begin
      priority if (p.row == q.row) begin
         x = '{p.row, next_coord(p.col)};
         y = '{q.row, next_coord(q.col)};
      end else if (p.col == q.col) begin
         x = '{next_coord(p.row), p.col};
         y = '{next_coord(q.row), q.col};
      end else begin
         x = '{p.row, q.col};
         y = '{q.row, p.col};
      end
   end

   assign cipher_first  = ascii_at(x);
   assign cipher_second = ascii_at(y);

endmodule

FILE: hw/rtl/playfair_stream_encryptor_core.sv
// ----------------------------------------------------------------------------
// playfair_stream_encryptor_core
// Filters text bytes, pairs letters into digraphs and Playfair-encrypts them.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      per transfer
//  req_chan  in   char_in[7:0], end_of_message                 one raw byte
//  rsp_chan  out  cipher_letter[6:0], last_of_run, message_done one letter
//
//  A byte is taken every cycle while the job register can move on; its
//  digraphs (none, one or two) go through the square lookup into a 4-letter
//  result buffer that drains one letter a cycle while rsp_chan is ready, so
//  a byte yields 0, 2 or 4 letters. Pairing state updates on the req transfer
//  itself. Reset clears the held letter, buf_idx and all valid flags; rsp
//  stalls hold the buffer, then the job register, then req_chan.ready.
// ----------------------------------------------------------------------------
module playfair_stream_encryptor_core (
   input logic      clock,
   input logic      reset,
   plf_req_if.sink   req_chan,
   plf_rsp_if.source rsp_chan
);
   import plf_pkg::*;

   // pairing state
   letter_type held_ff, held_in;
   logic       held_valid_ff, held_valid_in;

   // job register
   logic        job_valid_ff, job_valid_in;
   digraph_type job_pair_ff [2];
   logic        job_two_ff;
   logic        job_eom_ff;

   // result buffer
   logic      buf_valid_ff, buf_valid_in;
   ascii_type buf_letter_ff [4];
   logic [1:0] buf_idx_ff, buf_idx_in;
   logic [1:0] buf_last_ff;
   logic       buf_eom_ff;

   // decode
   byte_type   ch;
   logic       is_upper, is_lower, is_letter;
   letter_type raw_letter, letter;
   letter_type mid_held;
   logic       mid_valid;
   logic       pair_a, flush;
   digraph_type pair_a_val, flush_val;
   digraph_type slot_in [2];
   logic        two_in;
   logic        accept, job_move, buf_pop, buf_free, buf_last;
   ascii_type   enc_letter [4];

   assign ch        = req_chan.char_in;
   assign is_upper  = (ch >= BYTE_UPPER_A) && (ch <= BYTE_UPPER_Z);
   assign is_lower  = (ch >= BYTE_LOWER_A) && (ch <= BYTE_LOWER_Z);
   assign is_letter = is_upper || is_lower;
   assign raw_letter = is_upper ? letter_type'(ch - BYTE_UPPER_A)
                                : letter_type'(ch - BYTE_LOWER_A);
   assign letter    = (raw_letter == LETTER_J) ? LETTER_I : raw_letter;

   always_comb begin
      mid_held   = held_ff;
      mid_valid  = held_valid_ff;
      pair_a     = 1'b0;
      pair_a_val = '{held_ff, LETTER_X};
      if (is_letter) begin
         priority if (!held_valid_ff) begin
            mid_held  = letter;
            mid_valid = 1'b1;
         end else if (held_ff == letter) begin
            pair_a   = 1'b1;
            mid_held = letter;
         end else begin
            pair_a     = 1'b1;
            pair_a_val = '{held_ff, letter};
            mid_held   = '0;
            mid_valid  = 1'b0;
         end
      end
      flush     = req_chan.end_of_message && mid_valid;
      flush_val = '{mid_held, LETTER_X};
      held_in       = flush ? '0 : mid_held;
      held_valid_in = flush ? 1'b0 : mid_valid;
      slot_in[0]    = pair_a ? pair_a_val : flush_val;
      slot_in[1]    = flush_val;
      two_in        = pair_a && flush;
   end

   assign buf_last = (buf_idx_ff == buf_last_ff);
   assign buf_pop  = rsp_chan.valid && rsp_chan.ready && buf_last;
   assign buf_free = !buf_valid_ff || buf_pop;
   assign job_move = job_valid_ff && buf_free;
   assign req_chan.ready = !job_valid_ff || job_move;
   assign accept   = req_chan.valid && req_chan.ready;

   assign job_valid_in = accept ? (pair_a || flush) : (job_valid_ff && !job_move);

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_idx_in   = buf_idx_ff;
      if (rsp_chan.valid && rsp_chan.ready) begin
         buf_idx_in = buf_idx_ff + 2'd1;
         if (buf_last) begin
            buf_valid_in = 1'b0;
         end
      end
      if (job_move) begin
         buf_valid_in = 1'b1;
         buf_idx_in   = '0;
      end
   end

   plf_digraph_enc u_enc0 (
      .pair          (job_pair_ff[0]),
      .cipher_first  (enc_letter[0]),
      .cipher_second (enc_letter[1])
   );

   plf_digraph_enc u_enc1 (
      .pair          (job_pair_ff[1]),
      .cipher_first  (enc_letter[2]),
      .cipher_second (enc_letter[3])
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         job_valid_ff  <= 1'b0;
         buf_valid_ff  <= 1'b0;
         buf_idx_ff    <= '0;
      end else begin
         if (accept) begin
            held_ff       <= held_in;
            held_valid_ff <= held_valid_in;
         end
         job_valid_ff <= job_valid_in;
         buf_valid_ff <= buf_valid_in;
         buf_idx_ff   <= buf_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_pair_ff[0] <= slot_in[0];
         job_pair_ff[1] <= slot_in[1];
         job_two_ff     <= two_in;
         job_eom_ff     <= req_chan.end_of_message;
      end
      if (job_move) begin
         buf_letter_ff[0] <= enc_letter[0];
         buf_letter_ff[1] <= enc_letter[1];
         buf_letter_ff[2] <= enc_letter[2];
         buf_letter_ff[3] <= enc_letter[3];
         buf_last_ff      <= job_two_ff ? 2'd3 : 2'd1;
         buf_eom_ff       <= job_eom_ff;
      end
   end

   assign rsp_chan.valid         = buf_valid_ff;
   assign rsp_chan.cipher_letter = buf_letter_ff[buf_idx_ff];
   assign rsp_chan.last_of_run   = buf_last;
   assign rsp_chan.message_done  = buf_last && buf_eom_ff;

endmodule

FILE: hw/rtl/plf_checker.sv
// ----------------------------------------------------------------------------
// plf_checker
// Port-level checks on the encryptor's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module plf_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input plf_pkg::ascii_type  rsp_cipher_letter,
   input logic                rsp_last_of_run,
   input logic                rsp_message_done
);
   import plf_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_done) |-> rsp_last_of_run)
      else $error("message_done without last_of_run");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cipher_letter >= ASCII_A) && (rsp_cipher_letter <= ASCII_Z)
                    && (rsp_cipher_letter != ASCII_J))
      else $error("cipher letter outside the square");

   a_run_even: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("run broken before its last letter");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_cipher_letter)
                                    && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind playfair_stream_encryptor_core plf_checker u_plf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_cipher_letter (rsp_chan.cipher_letter),
   .rsp_last_of_run   (rsp_chan.last_of_run),
   .rsp_message_done  (rsp_chan.message_done)
);
